// File: design/sse_pkg.sv
// Shared types for the selection sort engine: controller/datapath command and status.
`default_nettype none
package sse_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef struct packed {
    logic collect;  // take input words into the store
    logic read_i;   // read the entry at the current sort position
    logic load_i;   // latch it as the running minimum, start the scan
    logic scan;     // walk the rest of the run through the comparator
    logic emit;     // send the minimum, swap, advance the position (or end the run)
  } cmd_t;

  typedef struct packed {
    logic run_end;    // last word of a run accepted this cycle
    logic scan_live;  // a read datum is waiting to be compared
    logic final_pos;  // sort position is the last element of the run
    logic out_free;   // output register can take a word this cycle
  } status_t;

endpackage
`default_nettype wire

// File: design/selection_sort_engine_core.sv
// Selection sort engine: collects a run of signed words, sorts ascending, streams them out.
//
// Input channel (in_*): one signed 32-bit word per beat, in_tlast marks the
// end of a run. Words are taken one per cycle while the engine is collecting.
// Up to MAX_ITEMS words are stored; further words of the run are dropped and
// every result of that run then carries out_tuser = 1.
// After the last word the engine sorts and emits; in_tready stays low until
// the final result of the run has been loaded into the output register.
// For each sort position one comparator walks the remaining entries of the
// store (one read port, one write port), one read per cycle, and the minimum
// is emitted once its pass ends and the output register can take it.
// Output channel (out_*): one registered word; a stalled receiver holds the
// word and pauses the sort at the next emit.
// Reset (rst_n low, synchronous) empties the store and clears the flags.
`default_nettype none
module selection_sort_engine_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [sse_pkg::VALUE_W-1:0] in_tdata,   // [31:0] value
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [sse_pkg::VALUE_W-1:0]      out_tdata,  // [31:0] sorted_value
  output logic                             out_tlast,
  output logic                             out_tuser   // [0] overflow
);

  sse_pkg::cmd_t    cmd;
  sse_pkg::status_t sts;

  assign in_tready = cmd.collect;

  sse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  sse_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// File: design/sse_ctrl.sv
// Controller state machine of the selection sort engine.
`default_nettype none
module sse_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sse_pkg::status_t sts,
  output sse_pkg::cmd_t        cmd
);

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_READ_I  = 3'd1;
  localparam logic [2:0] ST_LOAD_I  = 3'd2;
  localparam logic [2:0] ST_SCAN    = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_COLLECT: begin
        cmd.collect = 1'b1;
        if (sts.run_end) begin
          state_nxt = ST_READ_I;
        end
      end
      ST_READ_I: begin
        cmd.read_i = 1'b1;
        state_nxt  = ST_LOAD_I;
      end
      ST_LOAD_I: begin
        cmd.load_i = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (!sts.scan_live) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.final_pos ? ST_COLLECT : ST_READ_I;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/sse_dpath.sv
// Datapath of the selection sort engine: element store, comparator, counters, output register.
`default_nettype none
module sse_dpath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sse_pkg::cmd_t                 cmd,
  output sse_pkg::status_t                   sts,
  input  wire logic                          in_tvalid,
  input  wire logic [sse_pkg::VALUE_W-1:0]   in_tdata,
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [sse_pkg::VALUE_W-1:0]        out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  logic [sse_pkg::VALUE_W-1:0] mem [MAX_ITEMS];

  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] cmp_pos_r, cmp_pos_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [CW-1:0] min_pos_r, min_pos_nxt;
  logic [sse_pkg::VALUE_W-1:0] min_val_r, min_val_nxt;
  logic [sse_pkg::VALUE_W-1:0] ival_r, ival_nxt;
  logic [sse_pkg::VALUE_W-1:0] rdata_r;
  logic          out_valid_r, out_valid_nxt;
  logic [sse_pkg::VALUE_W-1:0] out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [sse_pkg::VALUE_W-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] i_plus1;
  logic          final_pos;
  logic          is_less;

  assign accept    = in_tvalid & cmd.collect;
  assign i_plus1   = i_r + ONE;
  assign final_pos = (i_plus1 == count_r);
  assign is_less   = $signed(rdata_r) < $signed(min_val_r);

  assign sts.run_end   = accept & in_tlast;
  assign sts.scan_live = cmp_v_r;
  assign sts.final_pos = final_pos;
  assign sts.out_free  = ~out_valid_r | out_tready;

  // store write port: filled while collecting, swap target on emit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = in_tdata;
    if (accept && count_r < MAX_CNT) begin
      wr_en = 1'b1;
    end else if (cmd.emit) begin
      wr_en   = 1'b1;
      wr_addr = min_pos_r[AW-1:0];
      wr_data = ival_r;
    end
  end

  always_comb begin
    rd_addr = j_r[AW-1:0];
    if (cmd.read_i) begin
      rd_addr = i_r[AW-1:0];
    end else if (cmd.load_i) begin
      rd_addr = i_plus1[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cmp_pos_nxt   = cmp_pos_r;
    cmp_v_nxt     = cmp_v_r;
    min_pos_nxt   = min_pos_r;
    min_val_nxt   = min_val_r;
    ival_nxt      = ival_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (accept) begin
      if (count_r < MAX_CNT) begin
        count_nxt = count_r + ONE;
      end else begin
        dropped_nxt = 1'b1;
      end
    end

    if (cmd.load_i) begin
      min_val_nxt = rdata_r;
      ival_nxt    = rdata_r;
      min_pos_nxt = i_r;
      cmp_pos_nxt = i_plus1;
      cmp_v_nxt   = (i_plus1 < count_r);
      j_nxt       = i_r + TWO;
    end

    if (cmd.scan && cmp_v_r) begin
      if (is_less) begin
        min_val_nxt = rdata_r;
        min_pos_nxt = cmp_pos_r;
      end
      cmp_pos_nxt = j_r;
      cmp_v_nxt   = (j_r < count_r);
      if (j_r < count_r) begin
        j_nxt = j_r + ONE;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = min_val_r;
      out_last_nxt  = final_pos;
      out_ovf_nxt   = dropped_r;
      if (final_pos) begin
        i_nxt       = '0;
        count_nxt   = '0;
        dropped_nxt = 1'b0;
      end else begin
        i_nxt = i_plus1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      i_r         <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      i_r         <= i_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    j_r        <= j_nxt;
    cmp_pos_r  <= cmp_pos_nxt;
    min_pos_r  <= min_pos_nxt;
    min_val_r  <= min_val_nxt;
    ival_r     <= ival_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule
`default_nettype wire
